>>> src/mtrd_pkg.sv
package mtrd_pkg;

    localparam int unsigned TBL_N = 624;
    localparam int unsigned TBL_M = 397;
    localparam int unsigned ADDR_W = $clog2(TBL_N);
    localparam int unsigned BIT_W = 5;

    localparam logic [31:0] TWIST_XOR = 32'h9908_B0DF;
    localparam logic [31:0] SEED_MUL = 32'd69069;
    localparam logic [31:0] TEMPER_B = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C = 32'hEFC6_0000;
    localparam logic [31:0] RESET_SEED = 32'd1;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TBL_N - 1);
    localparam logic [ADDR_W-1:0] FAR_FWD = ADDR_W'(TBL_M);
    localparam logic [ADDR_W-1:0] FAR_BACK = ADDR_W'(TBL_N - TBL_M);

    localparam logic [1:0] RD_POS = 2'd0;
    localparam logic [1:0] RD_NEXT = 2'd1;
    localparam logic [1:0] RD_FAR = 2'd2;

    typedef struct packed {
        logic       fill_step;
        logic [1:0] rd_sel;
        logic       cap_a;
        logic       cap_b;
        logic       mix;
        logic       take_bound;
        logic       div_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic div_last;
        logic bound_zero;
        logic out_free;
    } status_t;

    function automatic logic [31:0] mix_word(
        input logic [31:0] hi_src,
        input logic [31:0] lo_src,
        input logic [31:0] far
    );
        logic [31:0] y;
        logic [31:0] r;
        begin
            y = {hi_src[31], lo_src[30:0]};
            r = far ^ (y >> 1);
            if (y[0])
            begin
                r = r ^ TWIST_XOR;
            end
            return r;
        end
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        begin
            y = w;
            y = y ^ (y >> 11);
            y = y ^ ((y << 7) & TEMPER_B);
            y = y ^ ((y << 15) & TEMPER_C);
            y = y ^ (y >> 18);
            return y;
        end
    endfunction

endpackage

>>> src/mtrd_if.sv
interface mtrd_bound_if (input logic clk);
    logic        valid;
    logic        ready;
    logic [31:0] bound;

    modport source (output valid, output bound, input ready);
    modport sink (input valid, input bound, output ready);
endinterface

interface mtrd_value_if (input logic clk);
    logic        valid;
    logic        ready;
    logic [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

>>> src/mtrd_ctrl.sv
module mtrd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             in_valid,
    output logic             in_ready,
    input  mtrd_pkg::status_t sts,
    output mtrd_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_FILL = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RA   = 3'd2;
    localparam logic [2:0] S_RB   = 3'd3;
    localparam logic [2:0] S_RC   = 3'd4;
    localparam logic [2:0] S_MIX  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.rd_sel = mtrd_pkg::RD_POS;
        in_ready = 1'b0;
        case (state_reg)
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take_bound = in_valid;
                if (in_valid)
                begin
                    state_next = S_RA;
                end
            end
            S_RA:
            begin
                cmd.rd_sel = mtrd_pkg::RD_POS;
                state_next = S_RB;
            end
            S_RB:
            begin
                cmd.rd_sel = mtrd_pkg::RD_NEXT;
                cmd.cap_a = 1'b1;
                state_next = S_RC;
            end
            S_RC:
            begin
                cmd.rd_sel = mtrd_pkg::RD_FAR;
                cmd.cap_b = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix = 1'b1;
                state_next = sts.bound_zero ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
        if (cfg_we)
        begin
            state_next = S_FILL;
        end
    end

`ifndef SYNTHESIS
    a_fill_on_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> state_reg == S_FILL)
        else $error("seed write did not start a refill");
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmd.fill_step && !cmd.div_step && !cmd.mix)
        else $error("input taken while busy");
    a_mix_follows_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mix && !$past(cfg_we)) |-> $past(cmd.cap_b))
        else $error("mix without far read");
`endif

endmodule

>>> src/mtrd_dp.sv
module mtrd_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_data,
    input  logic [31:0]       in_bound,
    output logic              out_valid,
    output logic [31:0]       out_value,
    input  logic              out_ready,
    input  mtrd_pkg::cmd_t    cmd,
    output mtrd_pkg::status_t sts
);

    localparam int unsigned AW = mtrd_pkg::ADDR_W;

    logic [31:0] mem [mtrd_pkg::TBL_N];
    logic [31:0] rdata_reg;

    logic [31:0]   fill_reg, fill_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [mtrd_pkg::BIT_W-1:0] bit_reg, bit_next;
    logic [31:0] bound_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] y_reg, y_next;
    logic [31:0] rem_reg, rem_next;
    logic        valid_reg, valid_next;
    logic [31:0] value_reg;

    logic [AW-1:0] pos_inc;
    logic [AW-1:0] pos_far;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [31:0]   mixed;
    logic [32:0]   trial;

    assign pos_inc = (pos_reg == mtrd_pkg::LAST_ADDR) ? '0 : pos_reg + AW'(1);
    assign pos_far = (pos_reg < mtrd_pkg::FAR_BACK) ? pos_reg + mtrd_pkg::FAR_FWD
                                                    : pos_reg - mtrd_pkg::FAR_BACK;

    always_comb
    begin
        case (cmd.rd_sel)
            mtrd_pkg::RD_POS:  rd_addr = pos_reg;
            mtrd_pkg::RD_NEXT: rd_addr = pos_inc;
            mtrd_pkg::RD_FAR:  rd_addr = pos_far;
            default:           rd_addr = pos_reg;
        endcase
    end

    assign mixed = mtrd_pkg::mix_word(a_reg, b_reg, rdata_reg);
    assign wr_en = cmd.fill_step | cmd.mix;
    assign wr_addr = cmd.fill_step ? cnt_reg : pos_reg;
    assign wr_data = cmd.fill_step ? fill_reg : mixed;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign trial = {rem_reg, y_reg[31]};

    always_comb
    begin
        fill_next = fill_reg;
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        bit_next = bit_reg;
        y_next = y_reg;
        rem_next = rem_reg;
        valid_next = valid_reg;
        if (out_valid && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        if (cmd.fill_step)
        begin
            fill_next = fill_reg * mtrd_pkg::SEED_MUL;
            cnt_next = cnt_reg + AW'(1);
        end
        if (cmd.mix)
        begin
            y_next = mtrd_pkg::temper(mixed);
            rem_next = '0;
            bit_next = '0;
            pos_next = pos_inc;
        end
        if (cmd.div_step)
        begin
            y_next = y_reg << 1;
            bit_next = bit_reg + mtrd_pkg::BIT_W'(1);
            if (trial >= {1'b0, bound_reg})
            begin
                rem_next = 32'(trial - {1'b0, bound_reg});
            end
            else
            begin
                rem_next = trial[31:0];
            end
        end
        if (cfg_we)
        begin
            fill_next = cfg_data;
            cnt_next = '0;
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= mtrd_pkg::RESET_SEED;
            cnt_reg <= '0;
            pos_reg <= '0;
            bit_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
            bit_reg <= bit_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
        rem_reg <= rem_next;
        if (cmd.take_bound)
        begin
            bound_reg <= in_bound;
        end
        if (cmd.cap_a)
        begin
            a_reg <= rdata_reg;
        end
        if (cmd.cap_b)
        begin
            b_reg <= rdata_reg;
        end
        if (cmd.out_load)
        begin
            value_reg <= (bound_reg == '0) ? y_reg : rem_reg;
        end
    end

    assign sts.fill_last = (cnt_reg == mtrd_pkg::LAST_ADDR);
    assign sts.div_last = (bit_reg == '1);
    assign sts.bound_zero = (bound_reg == '0);
    assign sts.out_free = !valid_reg || out_ready;

    assign out_valid = valid_reg;
    assign out_value = value_reg;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= mtrd_pkg::LAST_ADDR)
        else $error("draw position out of range");
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.fill_step && cmd.mix))
        else $error("fill and twist write together");
    a_rem_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.div_step) |-> rem_reg < bound_reg)
        else $error("remainder not reduced");
`endif

endmodule

>>> src/mt19937_random_draw.sv
// channel  dir  signals                 meaning
// req      in   valid ready bound[31:0] draw request with modulus
// rsp      out  valid ready value[31:0] tempered word mod bound
// cfg      in   cfg_we cfg_data[31:0]   seed write, refills table
//
// a word takes three reads of the state memory (one read, one write port),
// one twist/temper step and 32 restoring divide steps, none when bound is 0
// after reset or a seed write the 624-word table is refilled, req not ready
// rsp is a register; the next word is taken while a result waits
module mt19937_random_draw (
    input  logic         clk,
    input  logic         rst_n,
    mtrd_bound_if.sink   req,
    mtrd_value_if.source rsp,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_data
);

    mtrd_pkg::cmd_t    cmd;
    mtrd_pkg::status_t sts;

    mtrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mtrd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_bound  (req.bound),
        .out_valid (rsp.valid),
        .out_value (rsp.value),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
